// ===== sv/huffman_code_builder_defines.svh =====
// assertion macros used by the huffman code builder sequencer (hcb_ctrl)
`ifndef HUFFMAN_CODE_BUILDER_DEFINES_SVH
`define HUFFMAN_CODE_BUILDER_DEFINES_SVH

// same-cycle implication
`define HCB_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("hcb check failed");

// next-cycle implication
`define HCB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("hcb check failed");

`endif

// ===== sv/hcb_pkg.sv =====
package hcb_pkg;
    localparam int MAX_SYMBOLS_DEF = 64;
    localparam int IN_W     = 32;
    localparam int WEIGHT_W = 38;
    localparam int IDX_W    = 6;
    localparam int LEN_W    = 6;
    localparam int CODE_W   = 63;

    typedef struct packed {
        logic load;
        logic scan_init;
        logic scan_step;
        logic take;
        logic merge;
        logic root;
        logic visit;
        logic child;
        logic pop_issue;
        logic pop_load;
        logic clear;
    } t_cmd;

    typedef struct packed {
        logic live_gt1;
        logic scan_last;
        logic second_pass;
        logic leaf;
        logic stack_empty;
    } t_sts;
endpackage

// ===== sv/huffman_code_builder.sv =====
// huffman code builder
// input channel (i_in_valid / o_in_ready): one transaction per symbol weight;
//   the symbol index is its load order; i_last_symbol ends the set
// weights past MAX_SYMBOLS are dropped, a set last flag still starts the build
// build: two minimum scans over the node memory per merge, each scan reading
//   one node per cycle from the weight memory and ending in a take step, then
//   a merge and a check step
// output channel (o_out_valid / i_out_ready): one transaction per symbol in
//   left-first preorder, with code length and right-aligned code bits;
//   o_last_code marks the final one; a single symbol gets length 0
// output walk: a visit and a child step per internal node, a visit, an output
//   and a pop step per leaf (no pop for the last leaf) while the receiver is ready
// a stall on the output simply holds the current result; no input is taken
//   until the last code has been accepted
// reset (synchronous, active low) empties the node set and returns to loading
// first weight can be accepted in the cycle after reset is released
module huffman_code_builder #(
    parameter int MAX_SYMBOLS = hcb_pkg::MAX_SYMBOLS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [hcb_pkg::IN_W-1:0]    i_symbol_weight,
    input  logic                        i_last_symbol,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [hcb_pkg::IDX_W-1:0]   o_symbol_index,
    output logic [hcb_pkg::LEN_W-1:0]   o_code_length,
    output logic [hcb_pkg::CODE_W-1:0]  o_code_bits,
    output logic                        o_last_code
);
    import hcb_pkg::*;

    // command and status between sequencer and datapath
    t_cmd w_cmd;
    t_sts w_sts;

    hcb_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_last_symbol (i_last_symbol),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_cmd         (w_cmd),
        .i_sts         (w_sts)
    );

    hcb_datapath #(.MAX_SYMBOLS(MAX_SYMBOLS)) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_symbol_weight (i_symbol_weight),
        .i_last_symbol   (i_last_symbol),
        .o_symbol_index  (o_symbol_index),
        .o_code_length   (o_code_length),
        .o_code_bits     (o_code_bits),
        .o_last_code     (o_last_code)
    );
endmodule

// ===== sv/hcb_datapath.sv =====
module hcb_datapath #(
    parameter int MAX_SYMBOLS = hcb_pkg::MAX_SYMBOLS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  hcb_pkg::t_cmd               i_cmd,
    output hcb_pkg::t_sts               o_sts,
    input  logic [hcb_pkg::IN_W-1:0]    i_symbol_weight,
    input  logic                        i_last_symbol,
    output logic [hcb_pkg::IDX_W-1:0]   o_symbol_index,
    output logic [hcb_pkg::LEN_W-1:0]   o_code_length,
    output logic [hcb_pkg::CODE_W-1:0]  o_code_bits,
    output logic                        o_last_code
);
    import hcb_pkg::*;

    localparam int NODE_SLOTS = 2 * MAX_SYMBOLS - 1;
    localparam int NODE_W     = $clog2(2 * MAX_SYMBOLS);
    localparam int LC_W       = $clog2(MAX_SYMBOLS + 1);
    localparam int SP_W       = $clog2(MAX_SYMBOLS);
    localparam int STACK_D    = MAX_SYMBOLS;
    localparam int SE_W       = NODE_W + LEN_W + CODE_W;

    logic [WEIGHT_W-1:0] r_wmem [NODE_SLOTS];
    logic [2*NODE_W-1:0] r_cmem [NODE_SLOTS];
    logic [SE_W-1:0]     r_smem [STACK_D];
    logic [NODE_SLOTS-1:0] r_live;

    logic [NODE_W-1:0]   r_count, n_count, r_nsym;
    logic [LC_W-1:0]     r_live_cnt;
    logic [NODE_W-1:0]   r_addr, r_rd_i, r_best_i, r_a, r_b;
    logic [WEIGHT_W-1:0] r_rd_w, r_best_w, r_wa, r_wb;
    logic                r_rd_vld, r_rd_live, r_found, r_pass;
    logic [NODE_W-1:0]   r_cur;
    logic [LEN_W-1:0]    r_len;
    logic [CODE_W-1:0]   r_code;
    logic [2*NODE_W-1:0] r_rd_c;
    logic [SE_W-1:0]     r_rd_s;
    logic [SP_W-1:0]     r_sp;
    logic [CODE_W-1:0]   w_base;
    logic                w_room;

    assign w_room  = (r_count < NODE_W'(MAX_SYMBOLS));
    assign n_count = w_room ? NODE_W'(r_count + 1'b1) : r_count;
    assign w_base  = {r_code[CODE_W-2:0], 1'b0};

    assign o_sts.live_gt1    = (r_live_cnt > LC_W'(1));
    assign o_sts.scan_last   = (r_addr == NODE_W'(r_count - 1'b1));
    assign o_sts.second_pass = r_pass;
    assign o_sts.leaf        = (r_cur < r_nsym);
    assign o_sts.stack_empty = (r_sp == '0);

    // node memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && w_room) begin
            r_wmem[r_count] <= WEIGHT_W'(i_symbol_weight);
        end else if (i_cmd.merge) begin
            r_wmem[r_count] <= r_wa + r_wb;
            r_cmem[r_count] <= {r_a, r_b};
        end
        if (i_cmd.scan_step) begin
            r_rd_w <= r_wmem[r_addr];
        end
        if (i_cmd.visit) begin
            r_rd_c <= r_cmem[r_cur];
        end
        if (i_cmd.child) begin
            r_smem[r_sp] <= {r_rd_c[NODE_W-1:0], LEN_W'(r_len + 1'b1), w_base | CODE_W'(1)};
        end
        if (i_cmd.pop_issue) begin
            r_rd_s <= r_smem[SP_W'(r_sp - 1'b1)];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_live_cnt <= '0;
            r_live     <= '0;
            r_rd_vld   <= 1'b0;
            r_found    <= 1'b0;
            r_pass     <= 1'b0;
            r_sp       <= '0;
        end else begin
            r_rd_vld <= i_cmd.scan_step;
            if (i_cmd.load && w_room) begin
                r_live[r_count] <= 1'b1;
                r_count         <= n_count;
                r_live_cnt      <= LC_W'(r_live_cnt + 1'b1);
            end
            if (i_cmd.scan_init) begin
                r_found <= 1'b0;
            end else if (r_rd_vld && r_rd_live && (!r_found || r_rd_w < r_best_w)) begin
                r_found <= 1'b1;
            end
            if (i_cmd.take) begin
                r_live[r_best_i] <= 1'b0;
                r_pass           <= !r_pass;
            end
            if (i_cmd.merge) begin
                r_live[r_count] <= 1'b1;
                r_count         <= NODE_W'(r_count + 1'b1);
                r_live_cnt      <= LC_W'(r_live_cnt - 1'b1);
            end
            if (i_cmd.root) begin
                r_sp <= '0;
            end else if (i_cmd.child) begin
                r_sp <= SP_W'(r_sp + 1'b1);
            end else if (i_cmd.pop_issue) begin
                r_sp <= SP_W'(r_sp - 1'b1);
            end
            if (i_cmd.clear) begin
                r_count    <= '0;
                r_live_cnt <= '0;
                r_live     <= '0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && i_last_symbol) begin
            r_nsym <= n_count;
        end
        if (i_cmd.scan_init) begin
            r_addr <= '0;
        end else if (i_cmd.scan_step) begin
            r_addr <= NODE_W'(r_addr + 1'b1);
        end
        if (i_cmd.scan_step) begin
            r_rd_i    <= r_addr;
            r_rd_live <= r_live[r_addr];
        end
        if (!i_cmd.scan_init && r_rd_vld && r_rd_live && (!r_found || r_rd_w < r_best_w)) begin
            r_best_w <= r_rd_w;
            r_best_i <= r_rd_i;
        end
        if (i_cmd.take) begin
            if (!r_pass) begin
                r_a  <= r_best_i;
                r_wa <= r_best_w;
            end else begin
                r_b  <= r_best_i;
                r_wb <= r_best_w;
            end
        end
        if (i_cmd.root) begin
            r_cur  <= NODE_W'(r_count - 1'b1);
            r_len  <= '0;
            r_code <= '0;
        end else if (i_cmd.child) begin
            r_cur  <= r_rd_c[2*NODE_W-1:NODE_W];
            r_len  <= LEN_W'(r_len + 1'b1);
            r_code <= w_base;
        end else if (i_cmd.pop_load) begin
            r_cur  <= r_rd_s[SE_W-1 -: NODE_W];
            r_len  <= r_rd_s[CODE_W +: LEN_W];
            r_code <= r_rd_s[CODE_W-1:0];
        end
        if (i_cmd.visit) begin
            o_symbol_index <= IDX_W'(r_cur);
            o_code_length  <= r_len;
            o_code_bits    <= r_code;
            o_last_code    <= (r_sp == '0);
        end
    end
endmodule

// ===== sv/hcb_ctrl.sv =====
`include "huffman_code_builder_defines.svh"

module hcb_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic          i_last_symbol,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output hcb_pkg::t_cmd o_cmd,
    input  hcb_pkg::t_sts i_sts
);
    import hcb_pkg::*;

    typedef enum logic [3:0] {
        S_LOAD, S_CHECK, S_SCAN, S_SCAN_END, S_TAKE, S_MERGE,
        S_VISIT, S_CHILD, S_OUT, S_POP
    } t_state;

    t_state r_state, n_state;

    assign o_in_ready  = (r_state == S_LOAD);
    assign o_out_valid = (r_state == S_OUT);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_LOAD: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_last_symbol) n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.live_gt1) begin
                    o_cmd.scan_init = 1'b1;
                    n_state = S_SCAN;
                end else begin
                    o_cmd.root = 1'b1;
                    n_state = S_VISIT;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_last) n_state = S_SCAN_END;
            end
            S_SCAN_END: n_state = S_TAKE;
            S_TAKE: begin
                o_cmd.take = 1'b1;
                if (i_sts.second_pass) begin
                    n_state = S_MERGE;
                end else begin
                    o_cmd.scan_init = 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_MERGE: begin
                o_cmd.merge = 1'b1;
                n_state = S_CHECK;
            end
            S_VISIT: begin
                o_cmd.visit = 1'b1;
                n_state = i_sts.leaf ? S_OUT : S_CHILD;
            end
            S_CHILD: begin
                o_cmd.child = 1'b1;
                n_state = S_VISIT;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    if (i_sts.stack_empty) begin
                        o_cmd.clear = 1'b1;
                        n_state = S_LOAD;
                    end else begin
                        o_cmd.pop_issue = 1'b1;
                        n_state = S_POP;
                    end
                end
            end
            S_POP: begin
                o_cmd.pop_load = 1'b1;
                n_state = S_VISIT;
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    `HCB_ASSERT_IMPL(a_excl, o_in_ready, !o_out_valid)
    `HCB_ASSERT_NEXT(a_build, i_in_valid && o_in_ready && i_last_symbol, !o_in_ready)
    `HCB_ASSERT_NEXT(a_done, o_out_valid && i_out_ready && i_sts.stack_empty, o_in_ready)
endmodule

// ===== sim/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import hcb_pkg::*;

    localparam int  MAX_SYM     = MAX_SYMBOLS_DEF;
    localparam int  SLOTS       = 2 * MAX_SYM - 1;
    // generous bound on the run length, covering the builds and the walks
    localparam int  CYCLE_LIMIT = 2000000;
    localparam int  TAIL_CYCLES = 64;

    typedef struct packed {
        logic [IDX_W-1:0]  index;
        logic [LEN_W-1:0]  length;
        logic [CODE_W-1:0] bits;
        logic              last;
    } t_code;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    logic [IN_W-1:0]     i_symbol_weight;
    logic                i_last_symbol;
    logic                o_out_valid;
    logic                i_out_ready;
    logic [IDX_W-1:0]    o_symbol_index;
    logic [LEN_W-1:0]    o_code_length;
    logic [CODE_W-1:0]   o_code_bits;
    logic                o_last_code;

    huffman_code_builder i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_symbol_weight (i_symbol_weight),
        .i_last_symbol   (i_last_symbol),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_symbol_index  (o_symbol_index),
        .o_code_length   (o_code_length),
        .o_code_bits     (o_code_bits),
        .o_last_code     (o_last_code)
    );

    // predictor state: weights of the set being loaded and the tree under build
    logic [IN_W-1:0]     set_weights[$];
    logic [WEIGHT_W-1:0] tree_weight[SLOTS];
    int                  tree_left[SLOTS];
    int                  tree_right[SLOTS];
    bit                  tree_live[SLOTS];
    int                  tree_count;
    t_code               pending_codes[$];

    int  mismatches = 0;
    bit  failed     = 0;
    int  cycle      = 0;
    bit  idle_on    = 1;   // random idle bursts on both channels
    int  hold_len   = 0;   // long receiver hold-off request
    int  stall_left = 0;

    // clock, 4 ns period
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // lightest live node, ties to the lower node number; the node leaves the set
    function automatic int take_min();
        int best;
        best = -1;
        for (int i = 0; i < tree_count; i++) begin
            if (tree_live[i] && (best < 0 || tree_weight[i] < tree_weight[best]))
                best = i;
        end
        tree_live[best] = 1'b0;
        return best;
    endfunction

    // merge the loaded set into a tree and queue its codes in preorder
    task automatic build_codes();
        int                nsym;
        int                live;
        int                a;
        int                b;
        int                sp;
        int                nd;
        int                stk_node[SLOTS + 1];
        int                stk_len[SLOTS + 1];
        logic [CODE_W-1:0] stk_code[SLOTS + 1];
        logic [CODE_W-1:0] base;
        t_code             c;
        t_code             walk[$];
        nsym = set_weights.size();
        for (int i = 0; i < nsym; i++) begin
            tree_weight[i] = WEIGHT_W'(set_weights[i]);
            tree_live[i]   = 1'b1;
        end
        tree_count = nsym;
        live       = nsym;
        while (live > 1) begin
            a = take_min();
            b = take_min();
            tree_weight[tree_count] = tree_weight[a] + tree_weight[b];
            tree_left[tree_count]   = a;
            tree_right[tree_count]  = b;
            tree_live[tree_count]   = 1'b1;
            tree_count++;
            live--;
        end
        // left-first preorder walk; right child pushed first so left pops first
        stk_node[0] = tree_count - 1;
        stk_len[0]  = 0;
        stk_code[0] = '0;
        sp = 1;
        while (sp > 0) begin
            sp--;
            nd = stk_node[sp];
            if (nd < nsym) begin
                c.index  = IDX_W'(nd);
                c.length = LEN_W'(stk_len[sp]);
                c.bits   = stk_code[sp];
                c.last   = 1'b0;
                walk.push_back(c);
            end else begin
                base = stk_code[sp] << 1;
                stk_node[sp + 1] = tree_left[nd];
                stk_len[sp + 1]  = stk_len[sp] + 1;
                stk_code[sp + 1] = base;
                stk_node[sp]     = tree_right[nd];
                stk_len[sp]      = stk_len[sp] + 1;
                stk_code[sp]     = base | 1'b1;
                sp += 2;
            end
        end
        walk[walk.size() - 1].last = 1'b1;
        foreach (walk[i]) pending_codes.push_back(walk[i]);
        for (int i = 0; i < SLOTS; i++) tree_live[i] = 1'b0;
        set_weights.delete();
    endtask

    // one input transaction; called at a falling edge, returns at a falling edge
    task automatic send_weight(input logic [IN_W-1:0] w, input logic last);
        if (idle_on && $urandom_range(0, 2) == 0) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_in_valid      = 1'b1;
        i_symbol_weight = w;
        i_last_symbol   = last;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        // weights past the symbol limit are dropped
        if (set_weights.size() < MAX_SYM) set_weights.push_back(w);
        if (last) build_codes();
        @(negedge i_clk);
    endtask

    // wait for every queued code, then let the block settle
    task automatic drain();
        i_in_valid = 1'b0;
        while (pending_codes.size() != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);
    endtask

    // receiver: ready with random stall bursts and an optional long hold-off
    always @(negedge i_clk) begin
        if (hold_len > 0) begin
            i_out_ready <= 1'b0;
            hold_len    <= hold_len - 1;
        end else if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left  <= stall_left - 1;
        end else if (idle_on && $urandom_range(0, 3) == 0) begin
            i_out_ready <= 1'b0;
            stall_left  <= $urandom_range(0, 3);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // checker: every accepted code against the oldest prediction
    always @(posedge i_clk) begin
        t_code want;
        t_code got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = '{o_symbol_index, o_code_length, o_code_bits, o_last_code};
            if (pending_codes.size() == 0) begin
                failed = 1;
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected code transaction: idx %0d len %0d bits %h",
                             got.index, got.length, got.bits);
            end else begin
                want = pending_codes.pop_front();
                if (got !== want) begin
                    failed = 1;
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"code mismatch: expected idx %0d len %0d bits %h last %b,",
                                  " got idx %0d len %0d bits %h last %b"},
                                 want.index, want.length, want.bits, want.last,
                                 got.index, got.length, got.bits, got.last);
                end
            end
        end
    end

    task automatic send_set(input logic [IN_W-1:0] ws[$]);
        foreach (ws[i]) send_weight(ws[i], i == ws.size() - 1);
    endtask

    // random weight: full range, small values for ties, an extreme, or a moderate value
    function automatic logic [IN_W-1:0] rand_weight(input int style);
        case (style)
            0: return $urandom();
            1: return $urandom_range(0, 3);
            2: return $urandom_range(0, 1) ? '1 : '0;
            default: return $urandom_range(0, 1000);
        endcase
    endfunction

    task automatic test_single_symbol();
        send_set('{32'd0});
        send_set('{32'hFFFF_FFFF});
        drain();
    endtask

    task automatic test_extremes();
        send_set('{32'd0, 32'hFFFF_FFFF, 32'd1, 32'h7FFF_FFFF});
        send_set('{32'hFFFF_FFFF, 32'hFFFF_FFFF});
        drain();
    endtask

    task automatic test_ties();
        send_set('{32'd5, 32'd5, 32'd5, 32'd5, 32'd5});
        send_set('{32'd0, 32'd0, 32'd0});
        drain();
    endtask

    // more weights than the symbol limit; the extras are dropped
    task automatic test_overflow();
        for (int i = 0; i < MAX_SYM + 2; i++)
            send_weight($urandom(), i == MAX_SYM + 1);
        drain();
    endtask

    // receiver holds off long while the sender keeps offering sets
    task automatic test_backpressure();
        hold_len = 3000;
        send_set('{32'd3, 32'd1, 32'd2});
        send_set('{32'd9, 32'd9, 32'd4, 32'd1});
        send_set('{32'd7, 32'd8});
        drain();
    endtask

    task automatic random_sets(input int items);
        int sent;
        int size;
        int style;
        sent = 0;
        while (sent < items) begin
            size  = ($urandom_range(0, 19) == 0) ? $urandom_range(20, MAX_SYM)
                                                  : $urandom_range(1, 8);
            style = $urandom_range(0, 3);
            for (int i = 0; i < size; i++)
                send_weight(rand_weight(style), i == size - 1);
            sent += size;
        end
        drain();
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_symbol_weight = '0;
        i_last_symbol   = 1'b0;
        i_out_ready     = 1'b0;
        for (int i = 0; i < SLOTS; i++) tree_live[i] = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_single_symbol();
        test_extremes();
        test_ties();
        test_overflow();
        test_backpressure();
        random_sets(140);
        // last stretch runs with no idling on either side
        idle_on = 0;
        random_sets(50);

        if (!failed && pending_codes.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
